[hw/rtl/citp_pkg.sv]
`default_nettype none

package citp_pkg;

	localparam int KIND_W   = 5;
	localparam int HANDLE_W = 16;
	localparam int EVENT_W  = 4;

	// Token kinds from the scanner.
	localparam logic [KIND_W-1:0] TK_END     = 5'd0;
	localparam logic [KIND_W-1:0] TK_CREATE  = 5'd1;
	localparam logic [KIND_W-1:0] TK_UNIQUE  = 5'd2;
	localparam logic [KIND_W-1:0] TK_INDEX   = 5'd3;
	localparam logic [KIND_W-1:0] TK_IF      = 5'd4;
	localparam logic [KIND_W-1:0] TK_NOT     = 5'd5;
	localparam logic [KIND_W-1:0] TK_EXISTS  = 5'd6;
	localparam logic [KIND_W-1:0] TK_IDENT   = 5'd7;
	localparam logic [KIND_W-1:0] TK_DOT     = 5'd8;
	localparam logic [KIND_W-1:0] TK_ON      = 5'd9;
	localparam logic [KIND_W-1:0] TK_LPAREN  = 5'd10;
	localparam logic [KIND_W-1:0] TK_RPAREN  = 5'd11;
	localparam logic [KIND_W-1:0] TK_COMMA   = 5'd12;
	localparam logic [KIND_W-1:0] TK_COLLATE = 5'd13;
	localparam logic [KIND_W-1:0] TK_ASC     = 5'd14;
	localparam logic [KIND_W-1:0] TK_DESC    = 5'd15;

	// Events reported for each token.
	localparam logic [EVENT_W-1:0] EV_NONE    = 4'd0;
	localparam logic [EVENT_W-1:0] EV_NAME    = 4'd1;
	localparam logic [EVENT_W-1:0] EV_TABLE   = 4'd2;
	localparam logic [EVENT_W-1:0] EV_COLUMN  = 4'd3;
	localparam logic [EVENT_W-1:0] EV_COLLATE = 4'd4;
	localparam logic [EVENT_W-1:0] EV_SORT    = 4'd5;
	localparam logic [EVENT_W-1:0] EV_COLDONE = 4'd6;
	localparam logic [EVENT_W-1:0] EV_ACCEPT  = 4'd7;
	localparam logic [EVENT_W-1:0] EV_ERROR   = 4'd8;
	localparam logic [EVENT_W-1:0] EV_EARLY   = 4'd9;
	localparam logic [EVENT_W-1:0] EV_IGNORED = 4'd10;

	typedef enum logic [17:0] {
		ST_START    = 18'h00001,
		ST_CREATE   = 18'h00002,
		ST_UNIQUE   = 18'h00004,
		ST_INDEX    = 18'h00008,
		ST_IF       = 18'h00010,
		ST_IFNOT    = 18'h00020,
		ST_IFNOTEX  = 18'h00040,
		ST_DB       = 18'h00080,
		ST_DBDOT    = 18'h00100,
		ST_NAME     = 18'h00200,
		ST_ON       = 18'h00400,
		ST_TABLE    = 18'h00800,
		ST_COLLIST  = 18'h01000,
		ST_COL      = 18'h02000,
		ST_COLLATE  = 18'h04000,
		ST_COLLNAME = 18'h08000,
		ST_SORT     = 18'h10000,
		ST_DONE     = 18'h20000
	} state_t;

endpackage

`default_nettype wire

[hw/rtl/create_index_token_parser_top.sv]
// Channel   Direction  Handshake           Payload
// token     in         in_valid/in_ready   first_token, token_kind, value_handle,
//                                          is_database_name
// event     out        out_valid/out_ready event_res, captured_handle, unique_index
//
// One token is taken per cycle while the result is not stalled; its event
// passes from the input register into the result register and is on the
// outputs from there.
// The parser state advances when a token moves from the input register into
// the result register, so at most one state transition is made per cycle.
// arst_n clears the valid flags, returns the parser to the start state and
// clears the unique flag.
// A stalled result holds the input register; in_ready stays high while that
// register is empty or is moving forward in the same cycle.
`default_nettype none

module create_index_token_parser_top #(
	parameter int HANDLE_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 first_token,
	input  wire logic [citp_pkg::KIND_W-1:0]          token_kind,
	input  wire logic [citp_pkg::HANDLE_W-1:0]        value_handle,
	input  wire logic                                 is_database_name,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [citp_pkg::EVENT_W-1:0]              event_res,
	output logic [citp_pkg::HANDLE_W-1:0]             captured_handle,
	output logic                                      unique_index
);

	// Captured text handles never carry more bits than the port holds.
	localparam int CAP_BITS = (HANDLE_BITS < citp_pkg::HANDLE_W) ?
		HANDLE_BITS : citp_pkg::HANDLE_W;

	logic                             valid_s1;
	logic                             first_s1;
	logic [citp_pkg::KIND_W-1:0]      kind_s1;
	logic [citp_pkg::HANDLE_W-1:0]    handle_s1;
	logic                             isdb_s1;

	logic                             valid_s2;
	logic [citp_pkg::EVENT_W-1:0]     event_s2;
	logic [CAP_BITS-1:0]              cap_s2;
	logic                             unique_s2;

	citp_pkg::state_t                 state_q;
	logic                             unique_q;

	citp_pkg::state_t                 cur_state;
	citp_pkg::state_t                 nxt_state;
	logic                             cur_unique;
	logic [citp_pkg::EVENT_W-1:0]     ev;
	logic                             cap;
	logic                             ident;
	logic                             sort_kw;
	logic                             advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign ident   = (kind_s1 == citp_pkg::TK_IDENT);
	assign sort_kw = (kind_s1 == citp_pkg::TK_ASC) || (kind_s1 == citp_pkg::TK_DESC);

	always_comb begin
		cur_state  = first_s1 ? citp_pkg::ST_START : state_q;
		cur_unique = first_s1 ? 1'b0 : unique_q;
		ev         = citp_pkg::EV_ERROR;
		nxt_state  = citp_pkg::ST_DONE;
		cap        = 1'b0;

		if (cur_state == citp_pkg::ST_DONE) begin
			ev = citp_pkg::EV_IGNORED;
		end else if (kind_s1 == citp_pkg::TK_END) begin
			// Lookahead states still owe a token, so an end there is a syntax error.
			ev = ((cur_state == citp_pkg::ST_IFNOT) || (cur_state == citp_pkg::ST_DBDOT)) ?
				citp_pkg::EV_ERROR : citp_pkg::EV_EARLY;
		end else begin
			unique case (cur_state)
				citp_pkg::ST_START: begin
					if (kind_s1 == citp_pkg::TK_CREATE) begin
						ev = citp_pkg::EV_NONE;
						nxt_state = citp_pkg::ST_CREATE;
					end
				end
				citp_pkg::ST_CREATE: begin
					if (kind_s1 == citp_pkg::TK_UNIQUE) begin
						ev = citp_pkg::EV_NONE;
						nxt_state = citp_pkg::ST_UNIQUE;
						cur_unique = 1'b1;
					end else if (kind_s1 == citp_pkg::TK_INDEX) begin
						ev = citp_pkg::EV_NONE;
						nxt_state = citp_pkg::ST_INDEX;
						cur_unique = 1'b0;
					end
				end
				citp_pkg::ST_UNIQUE: begin
					if (kind_s1 == citp_pkg::TK_INDEX) begin
						ev = citp_pkg::EV_NONE;
						nxt_state = citp_pkg::ST_INDEX;
					end
				end
				citp_pkg::ST_INDEX, citp_pkg::ST_IFNOTEX: begin
					if ((cur_state == citp_pkg::ST_INDEX) && (kind_s1 == citp_pkg::TK_IF)) begin
						ev = citp_pkg::EV_NONE;
						nxt_state = citp_pkg::ST_IF;
					end else if (ident && isdb_s1) begin
						ev = citp_pkg::EV_NONE;
						nxt_state = citp_pkg::ST_DB;
					end else if (ident) begin
						ev = citp_pkg::EV_NAME;
						cap = 1'b1;
						nxt_state = citp_pkg::ST_NAME;
					end
				end
				citp_pkg::ST_IF: begin
					if (kind_s1 == citp_pkg::TK_NOT) begin
						ev = citp_pkg::EV_NONE;
						nxt_state = citp_pkg::ST_IFNOT;
					end
				end
				citp_pkg::ST_IFNOT: begin
					if (kind_s1 == citp_pkg::TK_EXISTS) begin
						ev = citp_pkg::EV_NONE;
						nxt_state = citp_pkg::ST_IFNOTEX;
					end
				end
				citp_pkg::ST_DB: begin
					if (kind_s1 == citp_pkg::TK_DOT) begin
						ev = citp_pkg::EV_NONE;
						nxt_state = citp_pkg::ST_DBDOT;
					end
				end
				citp_pkg::ST_DBDOT: begin
					if (ident) begin
						ev = citp_pkg::EV_NAME;
						cap = 1'b1;
						nxt_state = citp_pkg::ST_NAME;
					end
				end
				citp_pkg::ST_NAME: begin
					if (kind_s1 == citp_pkg::TK_ON) begin
						ev = citp_pkg::EV_NONE;
						nxt_state = citp_pkg::ST_ON;
					end
				end
				citp_pkg::ST_ON: begin
					if (ident) begin
						ev = citp_pkg::EV_TABLE;
						cap = 1'b1;
						nxt_state = citp_pkg::ST_TABLE;
					end
				end
				citp_pkg::ST_TABLE: begin
					if (kind_s1 == citp_pkg::TK_LPAREN) begin
						ev = citp_pkg::EV_NONE;
						nxt_state = citp_pkg::ST_COLLIST;
					end
				end
				citp_pkg::ST_COLLIST: begin
					if (ident) begin
						ev = citp_pkg::EV_COLUMN;
						cap = 1'b1;
						nxt_state = citp_pkg::ST_COL;
					end
				end
				citp_pkg::ST_COLLATE: begin
					if (ident) begin
						ev = citp_pkg::EV_COLLATE;
						cap = 1'b1;
						nxt_state = citp_pkg::ST_COLLNAME;
					end
				end
				citp_pkg::ST_COL, citp_pkg::ST_COLLNAME, citp_pkg::ST_SORT: begin
					if ((cur_state == citp_pkg::ST_COL) && (kind_s1 == citp_pkg::TK_COLLATE)) begin
						ev = citp_pkg::EV_NONE;
						nxt_state = citp_pkg::ST_COLLATE;
					end else if ((cur_state != citp_pkg::ST_SORT) && sort_kw) begin
						ev = citp_pkg::EV_SORT;
						cap = 1'b1;
						nxt_state = citp_pkg::ST_SORT;
					end else if (kind_s1 == citp_pkg::TK_COMMA) begin
						ev = citp_pkg::EV_COLDONE;
						nxt_state = citp_pkg::ST_COLLIST;
					end else if (kind_s1 == citp_pkg::TK_RPAREN) begin
						ev = citp_pkg::EV_ACCEPT;
						nxt_state = citp_pkg::ST_DONE;
					end
				end
				default: begin
					ev = citp_pkg::EV_IGNORED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= citp_pkg::ST_START;
			unique_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
			if (advance) begin
				state_q  <= nxt_state;
				unique_q <= cur_unique;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			first_s1  <= first_token;
			kind_s1   <= token_kind;
			handle_s1 <= value_handle;
			isdb_s1   <= is_database_name;
		end
		if (advance) begin
			event_s2  <= ev;
			cap_s2    <= cap ? handle_s1[CAP_BITS-1:0] : '0;
			unique_s2 <= cur_unique;
		end
	end

	assign out_valid       = valid_s2;
	assign event_res       = event_s2;
	assign captured_handle = citp_pkg::HANDLE_W'(cap_s2);
	assign unique_index    = unique_s2;

	// Only text-capturing events may carry a nonzero handle.
	a_handle_only_on_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (captured_handle != '0)) |->
		((event_res == citp_pkg::EV_NAME) || (event_res == citp_pkg::EV_TABLE) ||
		 (event_res == citp_pkg::EV_COLUMN) || (event_res == citp_pkg::EV_COLLATE) ||
		 (event_res == citp_pkg::EV_SORT)))
		else $error("handle reported with a non-capturing event");

	// An accepted statement leaves the parser finished.
	a_accept_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (ev == citp_pkg::EV_ACCEPT)) |=> (state_q == citp_pkg::ST_DONE))
		else $error("parser not finished after accepted statement");

	// Back pressure on the input only comes from a held input register.
	a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled without a full pipeline");

	// A token moving forward always lands in the result register.
	a_advance_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced token lost");

	// A finished parser only reports ignored tokens until a restart.
	a_done_ignores: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !first_s1 && (state_q == citp_pkg::ST_DONE)) |->
		(ev == citp_pkg::EV_IGNORED))
		else $error("finished parser reported a live event");

endmodule

`default_nettype wire
